@@ design/cto_pkg.sv @@
// shared types and codes for the connection timeout queue
// no dependencies
`default_nettype none
package cto_pkg;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_DEL = 2'd1;
    localparam logic [1:0] REQ_CHK = 2'd2;
    localparam logic [1:0] REQ_CLR = 2'd3;

    localparam logic [1:0] STS_DONE = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_NONE = 2'd2;

    // read address selects
    localparam logic [1:0] RA_CNT_M1 = 2'd0;
    localparam logic [1:0] RA_IDX_M2 = 2'd1;
    localparam logic [1:0] RA_IDX    = 2'd2;
    localparam logic [1:0] RA_ZERO   = 2'd3;

    // write selects
    localparam logic [1:0] WA_OLD_IDX  = 2'd0;
    localparam logic [1:0] WA_NEW_IDX  = 2'd1;
    localparam logic [1:0] WA_NEW_ZERO = 2'd2;
    localparam logic [1:0] WA_OLD_J    = 2'd3;

    localparam int unsigned ADDR_W_APB = 3;
    localparam logic [0:0] REG_WAIT = 1'd0;
    localparam logic [0:0] REG_KICK = 1'd1;

    typedef struct packed {
        logic [31:0] deadline;
        logic [9:0]  owner;
        logic [31:0] seq;
    } t_entry;

    typedef struct packed {
        logic       in_ready;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       idx_load;
        logic       idx_clr;
        logic       idx_dec;
        logic       idx_inc;
        logic       j_inc;
        logic       rem_inc;
        logic       cnt_inc;
        logic       cnt_pop;
        logic       cnt_clr;
        logic       cnt_load_j;
        logic       pop_cap;
        logic       stat_set;
        logic [1:0] stat_code;
        logic       earl_cap;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic       in_fire;
        logic [1:0] in_type;
        logic       full;
        logic       empty;
        logic       idx_one;
        logic       idx_end;
        logic       gt_when;
        logic       gt_now;
        logic       match;
        logic       out_busy;
    } t_stat;

endpackage
`default_nettype wire

@@ design/cto_req_if.sv @@
// request and result channel interfaces
// depends on nothing
`default_nettype none
interface cto_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] now;
    logic [9:0]  conn_id;
    logic [31:0] sequence_req;
    modport source (output valid, req_type, now, conn_id, sequence_req, input ready);
    modport sink (input valid, req_type, now, conn_id, sequence_req, output ready);
endinterface

interface cto_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        expired_valid;
    logic [9:0]  expired_conn;
    logic [31:0] expired_seq;
    logic [6:0]  removed_count;
    logic [31:0] earliest;
    logic [6:0]  entry_count;
    modport source (output valid, status, expired_valid, expired_conn, expired_seq,
        removed_count, earliest, entry_count, input ready);
    modport sink (input valid, status, expired_valid, expired_conn, expired_seq,
        removed_count, earliest, entry_count, output ready);
endinterface
`default_nettype wire

@@ design/connection_timeout_queue_core.sv @@
// top level of the connection timeout queue
// depends on cto_pkg, the channel interfaces, cto_regs, cto_ctrl and cto_dp
// Holds up to DEPTH connection deadlines sorted by expiry in a ring memory, and serves one
// request transaction at a time, giving one result transaction each. Add and delete walk the
// table one entry a cycle through the single memory read port; a check that re-arms its entry
// adds such a walk. A new request is taken once the previous result has been taken. No
// clearing pass is needed after reset.
`default_nettype none
module connection_timeout_queue_core import cto_pkg::*; #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    cto_req_if.sink                    i_req,
    cto_res_if.source                  o_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W_APB-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);
    logic [15:0] wait_time;
    logic        kick;
    t_cmd        cmd;
    t_stat       stat;

    cto_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_wait_time(wait_time), .o_kick(kick)
    );

    cto_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_kick(kick), .i_stat(stat), .o_cmd(cmd)
    );

    cto_dp #(.DEPTH(DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_req, .o_res, .i_wait_time(wait_time), .i_cmd(cmd), .o_stat(stat)
    );
endmodule
`default_nettype wire

@@ design/cto_regs.sv @@
// configuration registers on the apb-style port
// depends on cto_pkg
`default_nettype none
module cto_regs import cto_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W_APB-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output logic      [15:0]           o_wait_time,
    output logic                       o_kick
);
    logic [15:0] r_wait;
    logic        r_kick;
    logic        wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait <= 16'd20;
            r_kick <= 1'b0;
        end else if (wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                REG_WAIT: r_wait <= pwdata[15:0];
                REG_KICK: r_kick <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WAIT: prdata = {16'd0, r_wait};
            REG_KICK: prdata = {31'd0, r_kick};
            default:  prdata = 32'd0;
        endcase
    end

    assign o_wait_time = r_wait;
    assign o_kick      = r_kick;
endmodule
`default_nettype wire

@@ design/cto_dp.sv @@
// datapath: entry memory as a ring, scan indices, counts and result registers
// depends on cto_pkg and the channel interfaces
`default_nettype none
module cto_dp import cto_pkg::*; #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    cto_req_if.sink        i_req,
    cto_res_if.source      o_res,
    input  wire logic [15:0] i_wait_time,
    input  wire t_cmd      i_cmd,
    output t_stat          o_stat
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_entry mem [DEPTH];
    t_entry r_rd;

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count, r_idx, r_j, r_removed;
    logic [31:0]   r_when, r_now, r_seq, r_xseq, r_earliest;
    logic [9:0]    r_conn, r_xconn;
    logic [1:0]    r_status;
    logic          r_xvalid, r_out_valid;

    logic          fire;
    logic [32:0]   sum;
    logic [AW-1:0] rd_addr, wr_addr;
    t_entry        wr_data, new_e;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] l);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, head} + {1'b0, l};
        if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
        return s[AW-1:0];
    endfunction

    assign fire = i_req.valid && i_req.ready;
    assign i_req.ready = i_cmd.in_ready;
    assign sum = {1'b0, i_req.now} + {17'd0, i_wait_time};
    assign new_e = '{deadline: r_when, owner: r_conn, seq: r_seq};

    always_comb begin
        unique case (i_cmd.rd_sel)
            RA_CNT_M1: rd_addr = phys(r_head, r_count - CW'(1));
            RA_IDX_M2: rd_addr = phys(r_head, r_idx - CW'(2));
            RA_IDX:    rd_addr = phys(r_head, r_idx);
            RA_ZERO:   rd_addr = r_head;
            default:   rd_addr = r_head;
        endcase
        unique case (i_cmd.wr_sel)
            WA_OLD_IDX:  begin wr_addr = phys(r_head, r_idx); wr_data = r_rd; end
            WA_NEW_IDX:  begin wr_addr = phys(r_head, r_idx); wr_data = new_e; end
            WA_NEW_ZERO: begin wr_addr = r_head; wr_data = new_e; end
            WA_OLD_J:    begin wr_addr = phys(r_head, r_j); wr_data = r_rd; end
            default:     begin wr_addr = r_head; wr_data = new_e; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) mem[wr_addr] <= wr_data;
        if (i_cmd.rd_en) r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_when    <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            r_now     <= i_req.now;
            r_conn    <= i_req.conn_id;
            r_seq     <= i_req.sequence_req;
            r_xvalid  <= 1'b0;
            r_xconn   <= '0;
            r_xseq    <= '0;
            r_removed <= '0;
            r_j       <= '0;
        end
        if (i_cmd.stat_set) r_status <= i_cmd.stat_code;
        else if (fire) r_status <= STS_DONE;
        if (i_cmd.pop_cap) begin
            r_xvalid <= 1'b1;
            r_xconn  <= r_rd.owner;
            r_xseq   <= r_rd.seq;
            r_conn   <= r_rd.owner;
            r_seq    <= r_rd.seq;
        end
        if (i_cmd.j_inc) r_j <= r_j + CW'(1);
        if (i_cmd.rem_inc) r_removed <= r_removed + CW'(1);
        if (i_cmd.idx_load) r_idx <= r_count;
        else if (i_cmd.idx_clr) r_idx <= '0;
        else if (i_cmd.idx_dec) r_idx <= r_idx - CW'(1);
        else if (i_cmd.idx_inc) r_idx <= r_idx + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_earliest  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) r_count <= r_count + CW'(1);
            else if (i_cmd.cnt_clr) r_count <= '0;
            else if (i_cmd.cnt_load_j) r_count <= r_j + CW'(r_rd.owner != r_conn);
            else if (i_cmd.cnt_pop) begin
                r_count <= r_count - CW'(1);
                r_head  <= phys(r_head, CW'(1));
            end
            if (i_cmd.earl_cap) r_earliest <= r_rd.deadline;
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (o_res.ready) r_out_valid <= 1'b0;
        end
    end

    assign o_stat.in_fire  = fire;
    assign o_stat.in_type  = i_req.req_type;
    assign o_stat.full     = (r_count == CW'(DEPTH));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.idx_one  = (r_idx == CW'(1));
    assign o_stat.idx_end  = (r_idx == r_count);
    assign o_stat.gt_when  = (r_rd.deadline > r_when);
    assign o_stat.gt_now   = (r_rd.deadline > r_now);
    assign o_stat.match    = (r_rd.owner == r_conn);
    assign o_stat.out_busy = r_out_valid;

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_status;
    assign o_res.expired_valid = r_xvalid;
    assign o_res.expired_conn  = r_xconn;
    assign o_res.expired_seq   = r_xseq;
    assign o_res.removed_count = 7'(r_removed);
    assign o_res.earliest      = r_earliest;
    assign o_res.entry_count   = 7'(r_count);
endmodule
`default_nettype wire

@@ design/cto_ctrl.sv @@
// controller state machine sequencing the table scans
// depends on cto_pkg
`default_nettype none
module cto_ctrl import cto_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_kick,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ADD_ST   = 4'd1;
    localparam logic [3:0] S_ADD_CMP  = 4'd2;
    localparam logic [3:0] S_ADD_PUT  = 4'd3;
    localparam logic [3:0] S_DEL_RD   = 4'd4;
    localparam logic [3:0] S_DEL_CMP  = 4'd5;
    localparam logic [3:0] S_CHK_RD   = 4'd6;
    localparam logic [3:0] S_CHK_CMP  = 4'd7;
    localparam logic [3:0] S_HEAD_RD  = 4'd8;
    localparam logic [3:0] S_HEAD_CAP = 4'd9;
    localparam logic [3:0] S_FIN      = 4'd10;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = !i_stat.out_busy;
                if (i_stat.in_fire) begin
                    unique case (i_stat.in_type)
                        REQ_ADD: begin
                            if (i_stat.full) begin
                                o_cmd.stat_set  = 1'b1;
                                o_cmd.stat_code = STS_FULL;
                                n_state = S_FIN;
                            end else n_state = S_ADD_ST;
                        end
                        REQ_DEL: begin
                            o_cmd.idx_clr = 1'b1;
                            n_state = i_stat.empty ? S_HEAD_RD : S_DEL_RD;
                        end
                        REQ_CHK: begin
                            if (i_stat.empty) begin
                                o_cmd.stat_set  = 1'b1;
                                o_cmd.stat_code = STS_NONE;
                                n_state = S_FIN;
                            end else n_state = S_CHK_RD;
                        end
                        REQ_CLR: begin
                            o_cmd.cnt_clr = 1'b1;
                            n_state = S_FIN;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_ADD_ST: begin
                if (i_stat.empty) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WA_NEW_ZERO;
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_HEAD_RD;
                end else begin
                    o_cmd.idx_load = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_CNT_M1;
                    n_state = S_ADD_CMP;
                end
            end
            S_ADD_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.gt_when) begin
                    o_cmd.wr_sel  = WA_OLD_IDX;
                    o_cmd.idx_dec = 1'b1;
                    if (i_stat.idx_one) n_state = S_ADD_PUT;
                    else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RA_IDX_M2;
                    end
                end else begin
                    o_cmd.wr_sel  = WA_NEW_IDX;
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_HEAD_RD;
                end
            end
            S_ADD_PUT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WA_NEW_ZERO;
                o_cmd.cnt_inc = 1'b1;
                n_state = S_HEAD_RD;
            end
            S_DEL_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RA_IDX;
                o_cmd.idx_inc = 1'b1;
                n_state = S_DEL_CMP;
            end
            S_DEL_CMP: begin
                if (i_stat.match) o_cmd.rem_inc = 1'b1;
                else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WA_OLD_J;
                    o_cmd.j_inc  = 1'b1;
                end
                if (i_stat.idx_end) begin
                    o_cmd.cnt_load_j = 1'b1;
                    n_state = S_HEAD_RD;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = RA_IDX;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_CHK_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RA_ZERO;
                n_state = S_CHK_CMP;
            end
            S_CHK_CMP: begin
                if (i_stat.gt_now) begin
                    o_cmd.stat_set  = 1'b1;
                    o_cmd.stat_code = STS_NONE;
                    n_state = S_FIN;
                end else begin
                    o_cmd.pop_cap = 1'b1;
                    o_cmd.cnt_pop = 1'b1;
                    n_state = i_kick ? S_HEAD_RD : S_ADD_ST;
                end
            end
            S_HEAD_RD: begin
                if (i_stat.empty) n_state = S_FIN;
                else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_ZERO;
                    n_state = S_HEAD_CAP;
                end
            end
            S_HEAD_CAP: begin
                o_cmd.earl_cap = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.out_load = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire
